// ===== hdl/bst_pkg.sv =====
// Shared types and constants for the byte stream tokenizer.
// Holds token kinds, mark bytes, the keyword table and the token group record.
// No dependencies.
package bst_pkg;

   localparam int VALUE_WIDTH = 63;
   localparam int KIND_WIDTH = 4;
   localparam int BYTE_WIDTH = 8;
   localparam int KEYWORD_LEN = 5;
   localparam int WLEN_WIDTH = 3;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

   localparam logic [BYTE_WIDTH-1:0] MARK_BYTE0 = 8'hEF;
   localparam logic [BYTE_WIDTH-1:0] MARK_BYTE1 = 8'hBB;
   localparam logic [BYTE_WIDTH-1:0] MARK_BYTE2 = 8'hBF;
   localparam logic [BYTE_WIDTH-1:0] END_BYTE = 8'h00;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_END = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_PRINT = 4'd2,
      KIND_INVALID = 4'd3,
      KIND_PLUS = 4'd4,
      KIND_MINUS = 4'd5,
      KIND_STAR = 4'd6,
      KIND_SLASH = 4'd7,
      KIND_LPAREN = 4'd8,
      KIND_RPAREN = 4'd9,
      KIND_SEMI = 4'd10
   } token_kind_type;

   // Up to three tokens produced by one text byte; only the first can be a number.
   typedef struct packed {
      token_kind_type kind0;
      token_kind_type kind1;
      token_kind_type kind2;
      logic [VALUE_WIDTH-1:0] value;
      logic [1:0] count;
   } token_group_type;

   function automatic logic [BYTE_WIDTH-1:0] keyword_char(input logic [WLEN_WIDTH-1:0] pos);
      logic [BYTE_WIDTH-1:0] c;
      case (pos)
         3'd0: c = "p";
         3'd1: c = "r";
         3'd2: c = "i";
         3'd3: c = "n";
         3'd4: c = "t";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/bst_scan.sv =====
// Input register and scanner state machine of the byte stream tokenizer.
// Turns each registered text byte into a group of zero to three tokens.
// Depends on bst_pkg.
module bst_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bst_pkg::BYTE_WIDTH-1:0] req_text_byte,
   input  logic                          emit_ready,
   output logic                          group_valid,
   output bst_pkg::token_group_type      group
);
   import bst_pkg::*;

   typedef enum logic [2:0] {
      MODE_MARK0 = 3'd0,
      MODE_MARK1 = 3'd1,
      MODE_MARK2 = 3'd2,
      MODE_IDLE  = 3'd3,
      MODE_NUM   = 3'd4,
      MODE_WORD  = 3'd5
   } mode_type;

   localparam int PROD_WIDTH = VALUE_WIDTH + 4;

   mode_type mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [WLEN_WIDTH-1:0] wlen_ff, wlen_in;
   logic wmatch_ff, wmatch_in;
   logic byte_valid_ff, byte_valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff, byte_in;

   logic [PROD_WIDTH-1:0] prod;
   logic [VALUE_WIDTH-1:0] acc_step;
   logic [3:0] digit;
   logic is_digit, is_alpha, is_space;
   logic held, emit_new, fire;
   token_kind_type new_kind, punct_kind;
   token_group_type grp;

   assign is_digit = (byte_ff >= "0") && (byte_ff <= "9");
   assign is_alpha = ((byte_ff >= "A") && (byte_ff <= "Z")) || ((byte_ff >= "a") && (byte_ff <= "z"));
   assign is_space = (byte_ff == " ") || ((byte_ff >= 8'h09) && (byte_ff <= 8'h0D));
   assign digit = byte_ff[3:0] - 4'd0;

   // Saturating multiply by ten and add, done as two shifts and two adds.
   always_comb begin
      prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {{(PROD_WIDTH-4){1'b0}}, digit};
      if (prod > {4'b0, VALUE_MAX}) begin
         acc_step = VALUE_MAX;
      end else begin
         acc_step = prod[VALUE_WIDTH-1:0];
      end
   end

   always_comb begin
      case (byte_ff)
         "+": punct_kind = KIND_PLUS;
         "-": punct_kind = KIND_MINUS;
         "*": punct_kind = KIND_STAR;
         "/": punct_kind = KIND_SLASH;
         "(": punct_kind = KIND_LPAREN;
         ")": punct_kind = KIND_RPAREN;
         ";": punct_kind = KIND_SEMI;
         default: punct_kind = KIND_INVALID;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in = acc_ff;
      wlen_in = wlen_ff;
      wmatch_in = wmatch_ff;
      grp.kind0 = KIND_INVALID;
      grp.kind1 = KIND_INVALID;
      grp.kind2 = KIND_INVALID;
      grp.value = '0;
      grp.count = 2'd0;
      held = 1'b0;
      emit_new = 1'b0;
      new_kind = KIND_INVALID;

      unique case (mode_ff)
         MODE_MARK0: begin
            if (byte_ff == MARK_BYTE0) begin
               mode_in = MODE_MARK1;
               held = 1'b1;
            end
         end
         MODE_MARK1: begin
            if (byte_ff == MARK_BYTE1) begin
               mode_in = MODE_MARK2;
               held = 1'b1;
            end else begin
               grp.count = 2'd1;
            end
         end
         MODE_MARK2: begin
            if (byte_ff == MARK_BYTE2) begin
               mode_in = MODE_IDLE;
               held = 1'b1;
            end else begin
               grp.count = 2'd2;
            end
         end
         MODE_NUM: begin
            if (is_digit) begin
               acc_in = acc_step;
               held = 1'b1;
            end else begin
               grp.kind0 = KIND_NUMBER;
               grp.value = acc_ff;
               grp.count = 2'd1;
            end
         end
         MODE_WORD: begin
            if (is_alpha) begin
               wmatch_in = wmatch_ff && (wlen_ff < WLEN_WIDTH'(KEYWORD_LEN))
                           && (keyword_char(wlen_ff) == byte_ff);
               if (wlen_ff < WLEN_WIDTH'(KEYWORD_LEN + 1)) begin
                  wlen_in = wlen_ff + 1'b1;
               end
               held = 1'b1;
            end else begin
               grp.kind0 = (wmatch_ff && (wlen_ff == WLEN_WIDTH'(KEYWORD_LEN)))
                           ? KIND_PRINT : KIND_INVALID;
               grp.count = 2'd1;
            end
         end
         default: ;
      endcase

      if (!held) begin
         mode_in = MODE_IDLE;
         acc_in = '0;
         wlen_in = '0;
         wmatch_in = 1'b1;
         if (byte_ff == END_BYTE) begin
            new_kind = KIND_END;
            emit_new = 1'b1;
            mode_in = MODE_MARK0;
         end else if (is_space) begin
            mode_in = MODE_IDLE;
         end else if (is_digit) begin
            acc_in = {{(VALUE_WIDTH-4){1'b0}}, digit};
            mode_in = MODE_NUM;
         end else if (is_alpha) begin
            wmatch_in = (byte_ff == keyword_char('0));
            wlen_in = WLEN_WIDTH'(1);
            mode_in = MODE_WORD;
         end else begin
            new_kind = punct_kind;
            emit_new = 1'b1;
         end
         if (emit_new) begin
            case (grp.count)
               2'd0: grp.kind0 = new_kind;
               2'd1: grp.kind1 = new_kind;
               default: grp.kind2 = new_kind;
            endcase
            grp.count = grp.count + 2'd1;
         end
      end
   end

   assign fire = byte_valid_ff && ((grp.count == 2'd0) || emit_ready);
   assign req_ready = !byte_valid_ff || fire;
   assign group_valid = fire && (grp.count != 2'd0);
   assign group = grp;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in = byte_ff;
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
         byte_in = req_text_byte;
      end else if (fire) begin
         byte_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MARK0;
         acc_ff <= '0;
         wlen_ff <= '0;
         wmatch_ff <= 1'b1;
         byte_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            mode_ff <= mode_in;
            acc_ff <= acc_in;
            wlen_ff <= wlen_in;
            wmatch_ff <= wmatch_in;
         end
         byte_valid_ff <= byte_valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule

// ===== hdl/bst_emit.sv =====
// Result register of the byte stream tokenizer.
// Holds one token group and hands its tokens out one per accepted request.
// Depends on bst_pkg.
module bst_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             group_valid,
   input  bst_pkg::token_group_type         group,
   output logic                             emit_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bst_pkg::KIND_WIDTH-1:0]   rsp_token_kind,
   output logic [bst_pkg::VALUE_WIDTH-1:0]  rsp_number_value,
   output logic                             rsp_last_of_run
);
   import bst_pkg::*;

   token_group_type grp_ff, grp_in;
   logic [1:0] left_ff, left_in;
   logic [1:0] pos_ff, pos_in;
   token_kind_type kind;
   logic pop;

   assign rsp_valid = (left_ff != 2'd0);
   assign pop = rsp_valid && rsp_ready;
   assign emit_ready = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_ready);

   always_comb begin
      case (pos_ff)
         2'd0: kind = grp_ff.kind0;
         2'd1: kind = grp_ff.kind1;
         default: kind = grp_ff.kind2;
      endcase
   end

   assign rsp_token_kind = kind;
   assign rsp_number_value = (kind == KIND_NUMBER) ? grp_ff.value : '0;
   assign rsp_last_of_run = (left_ff == 2'd1);

   always_comb begin
      grp_in = grp_ff;
      left_in = left_ff;
      pos_in = pos_ff;
      if (group_valid) begin
         grp_in = group;
         left_in = group.count;
         pos_in = 2'd0;
      end else if (pop) begin
         left_in = left_ff - 2'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
         pos_ff <= pos_in;
      end
      grp_ff <= grp_in;
   end

endmodule

// ===== hdl/byte_stream_tokenizer.sv =====
// Byte stream tokenizer: one text byte per request in, one token per request out.
// A token appears once the byte that causes it has passed the input register and the result
// register. One byte per cycle is taken while each byte yields at most one token and each
// token is taken when offered; a byte that yields more keeps the result register until its last
// token is taken, and a following byte with tokens waits; bytes that yield none never wait.
// Synchronous active-high reset empties both registers and rearms the mark check.
module byte_stream_tokenizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bst_pkg::BYTE_WIDTH-1:0]   req_text_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bst_pkg::KIND_WIDTH-1:0]   rsp_token_kind,
   output logic [bst_pkg::VALUE_WIDTH-1:0]  rsp_number_value,
   output logic                             rsp_last_of_run
);
   import bst_pkg::*;

   token_group_type group;
   logic group_valid;
   logic emit_ready;

   bst_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .emit_ready    (emit_ready),
      .group_valid   (group_valid),
      .group         (group)
   );

   bst_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .group_valid      (group_valid),
      .group            (group),
      .emit_ready       (emit_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

// ===== hdl/bst_checker.sv =====
// Port-level checks for the byte stream tokenizer, bound to the top level.
// Depends on bst_pkg and byte_stream_tokenizer.
module bst_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [bst_pkg::BYTE_WIDTH-1:0]   req_text_byte,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [bst_pkg::KIND_WIDTH-1:0]   rsp_token_kind,
   input logic [bst_pkg::VALUE_WIDTH-1:0]  rsp_number_value,
   input logic                             rsp_last_of_run
);
   import bst_pkg::*;

   // A waiting request keeps its byte until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_text_byte))
      else $error("waiting request changed");

   // A stalled token keeps its kind and position in the run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_last_of_run))
      else $error("stalled token changed");

   // The tokens of one byte follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("token run broken");

   // Only number tokens carry a value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != KIND_NUMBER) |-> (rsp_number_value == '0))
      else $error("value on a non-number token");

   // No token can appear in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token right after reset");

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);

// ===== sim/byte_stream_tokenizer_test.sv =====
// Self-checking bench for byte_stream_tokenizer: feeds directed and random texts byte by byte
// and compares every token against a behavioral lexer kept in a small scoreboard class.
// Depends on bst_pkg and the byte_stream_tokenizer RTL.
`timescale 1ns / 100ps

module byte_stream_tokenizer_test;
   import bst_pkg::*;

   localparam int RANDOM_BYTES = 400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 300;
   localparam int MAX_GAP = 10;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS = 100;
   localparam logic [55:0] OPERATOR_TEXT = "+-*/();";
   localparam logic [79:0] STRAY_TEXT = "!#%,.=?@_~";

   typedef enum logic [2:0] {
      SCAN_START = 3'd0,
      SCAN_EF_HELD = 3'd1,
      SCAN_EFBB_HELD = 3'd2,
      SCAN_IDLE = 3'd3,
      SCAN_NUMBER = 3'd4,
      SCAN_WORD = 3'd5
   } scan_mode_type;

   typedef struct {
      token_kind_type kind;
      logic [VALUE_WIDTH-1:0] value;
      logic last_of_run;
   } expected_token_type;

   class token_scoreboard;
      localparam logic [39:0] KEYWORD_TEXT = "print";

      expected_token_type pending_tokens[$];
      scan_mode_type mode;
      logic [VALUE_WIDTH-1:0] accumulator;
      logic [WLEN_WIDTH-1:0] word_length;
      logic word_is_keyword;
      int mismatch_count;
      int tokens_checked;
      int saturated_numbers;

      function new();
         mode = SCAN_START;
         accumulator = '0;
         word_length = '0;
         word_is_keyword = 1'b1;
         mismatch_count = 0;
         tokens_checked = 0;
         saturated_numbers = 0;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
      endfunction

      function void push_token(token_kind_type kind, logic [VALUE_WIDTH-1:0] value);
         expected_token_type t;
         t.kind = kind;
         t.value = value;
         t.last_of_run = 1'b0;
         if (kind == KIND_NUMBER && value == VALUE_MAX) saturated_numbers++;
         pending_tokens.push_back(t);
      endfunction

      function void add_letter(logic [7:0] b);
         if (word_length >= 5 || KEYWORD_TEXT[39 - 8 * word_length -: 8] != b)
            word_is_keyword = 1'b0;
         if (word_length < 6) word_length++;
      endfunction

      function void note_request(logic [7:0] b);
         int first;
         logic [63:0] digit;
         logic [63:0] room;
         first = pending_tokens.size();
         digit = {56'd0, b - 8'h30};
         if (mode == SCAN_START) begin
            if (b == MARK_BYTE0) begin
               mode = SCAN_EF_HELD;
               return;
            end
            mode = SCAN_IDLE;
         end else if (mode == SCAN_EF_HELD) begin
            if (b == MARK_BYTE1) begin
               mode = SCAN_EFBB_HELD;
               return;
            end
            push_token(KIND_INVALID, '0);
            mode = SCAN_IDLE;
         end else if (mode == SCAN_EFBB_HELD) begin
            if (b == MARK_BYTE2) begin
               mode = SCAN_IDLE;
               return;
            end
            push_token(KIND_INVALID, '0);
            push_token(KIND_INVALID, '0);
            mode = SCAN_IDLE;
         end

         if (mode == SCAN_NUMBER) begin
            if (is_digit(b)) begin
               room = ({1'b0, VALUE_MAX} - digit) / 64'd10;
               if ({1'b0, accumulator} > room) accumulator = VALUE_MAX;
               else accumulator = VALUE_WIDTH'(accumulator * 64'd10 + digit);
               return;
            end
            push_token(KIND_NUMBER, accumulator);
            mode = SCAN_IDLE;
         end else if (mode == SCAN_WORD) begin
            if (is_letter(b)) begin
               add_letter(b);
               return;
            end
            push_token((word_is_keyword && word_length == 5) ? KIND_PRINT : KIND_INVALID, '0);
            mode = SCAN_IDLE;
         end

         accumulator = '0;
         word_length = '0;
         word_is_keyword = 1'b1;
         if (b == END_BYTE) begin
            push_token(KIND_END, '0);
            mode = SCAN_START;
         end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            mode = SCAN_IDLE;
         end else if (is_digit(b)) begin
            accumulator = digit[VALUE_WIDTH-1:0];
            mode = SCAN_NUMBER;
         end else if (is_letter(b)) begin
            add_letter(b);
            mode = SCAN_WORD;
         end else begin
            mode = SCAN_IDLE;
            case (b)
               "+": push_token(KIND_PLUS, '0);
               "-": push_token(KIND_MINUS, '0);
               "*": push_token(KIND_STAR, '0);
               "/": push_token(KIND_SLASH, '0);
               "(": push_token(KIND_LPAREN, '0);
               ")": push_token(KIND_RPAREN, '0);
               ";": push_token(KIND_SEMI, '0);
               default: push_token(KIND_INVALID, '0);
            endcase
         end

         if (pending_tokens.size() > first)
            pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
      endfunction

      task report(string msg);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
      endtask

      task check_token(logic [KIND_WIDTH-1:0] kind, logic [VALUE_WIDTH-1:0] value, logic last);
         expected_token_type want;
         if (pending_tokens.size() == 0) begin
            report($sformatf("token kind %0d arrived with no request pending", kind));
            return;
         end
         want = pending_tokens.pop_front();
         tokens_checked++;
         if (kind != want.kind)
            report($sformatf("token %0d kind %0d, wanted %0d", tokens_checked, kind, want.kind));
         if (value != want.value)
            report($sformatf("token %0d value %0d, wanted %0d", tokens_checked, value, want.value));
         if (last != want.last_of_run)
            report($sformatf("token %0d last_of_run %0b, wanted %0b", tokens_checked, last,
                             want.last_of_run));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_WIDTH-1:0] req_text_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KIND_WIDTH-1:0] rsp_token_kind;
   logic [VALUE_WIDTH-1:0] rsp_number_value;
   logic rsp_last_of_run;

   token_scoreboard board = new();
   bit sender_quiet = 1'b0;
   bit receiver_quiet = 1'b0;
   bit long_hold_request = 1'b0;
   int bytes_sent = 0;
   int texts_sent = 0;
   int cycle_count = 0;

   byte_stream_tokenizer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind),
      .rsp_number_value(rsp_number_value),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task send_byte(logic [7:0] b);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.note_request(b);
      bytes_sent++;
   endtask

   task automatic send_text(ref logic [7:0] text[$]);
      foreach (text[i]) send_byte(text[i]);
      texts_sent++;
   endtask

   task pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_tokens.size() != 0);
   endtask

   function automatic void build_text(ref logic [7:0] text[$]);
      int pieces;
      int len;
      int idx;
      logic [7:0] c;
      text.delete();
      if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) text.push_back(8'($urandom_range(0, 255)));
         text.push_back(END_BYTE);
         return;
      end
      case ($urandom_range(0, 9))
         0, 1: text = {MARK_BYTE0, MARK_BYTE1, MARK_BYTE2};
         2: text = {MARK_BYTE0};
         3: text = {MARK_BYTE0, MARK_BYTE1};
         default: ;
      endcase
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 4);
               repeat (len) text.push_back(8'(8'h30 + $urandom_range(0, 9)));
            end
            2: begin
               for (int i = 0; i < 5; i++) text.push_back(8'("print" >> (8 * (4 - i))));
            end
            3: begin
               len = $urandom_range(1, 7);
               for (int i = 0; i < len; i++) begin
                  if (i < 5 && $urandom_range(0, 2) != 0) c = 8'("print" >> (8 * (4 - i)));
                  else if ($urandom_range(0, 1) == 0) c = 8'("a" + $urandom_range(0, 25));
                  else c = 8'("A" + $urandom_range(0, 25));
                  text.push_back(c);
               end
            end
            4, 5: begin
               idx = $urandom_range(0, 6);
               text.push_back(OPERATOR_TEXT[55 - 8 * idx -: 8]);
            end
            6: begin
               case ($urandom_range(0, 2))
                  0: c = 8'($urandom_range(8'h80, 8'hFF));
                  1: c = 8'($urandom_range(1, 8));
                  default: begin
                     idx = $urandom_range(0, 9);
                     c = STRAY_TEXT[79 - 8 * idx -: 8];
                  end
               endcase
               text.push_back(c);
            end
            7: text.push_back(MARK_BYTE0);
            default: ;
         endcase
         if ($urandom_range(0, 2) != 0) begin
            idx = $urandom_range(0, 5);
            text.push_back(idx == 5 ? 8'h20 : 8'h09 + 8'(idx));
         end
      end
      text.push_back(END_BYTE);
   endfunction

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_token(rsp_token_kind, rsp_number_value, rsp_last_of_run);
      end
   end

   initial begin
      logic [7:0] text[$];
      int random_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      text = {END_BYTE,
              MARK_BYTE0, MARK_BYTE1, MARK_BYTE2, "p", "r", "i", "n", "t", "9", END_BYTE,
              MARK_BYTE0, MARK_BYTE1, "(", MARK_BYTE0, "a", "5", 8'hFF, END_BYTE,
              MARK_BYTE0, END_BYTE,
              "+", "-", "*", "/", ")", ";", 8'h80, 8'h20, 8'h0D, END_BYTE};
      send_text(text);
      pause_until_drained();

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         build_text(text);
         sender_quiet = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         if (texts_sent == 8) begin
            long_hold_request = 1'b1;
            sender_quiet = 1'b1;
         end
         if (texts_sent == 20) pause_until_drained();
         send_text(text);
      end

      receiver_quiet = 1'b1;
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d text bytes in %0d texts and checked %0d tokens",
               bytes_sent, texts_sent, board.tokens_checked);
      $display("saturated numbers seen: %0d, mismatches: %0d",
               board.saturated_numbers, board.mismatch_count);
      if (board.mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
